FILE: rtl/wtoq_pkg.sv
// Shared types and constants for the wake-time ordered task queue.
// Used by the top level and by its port checker; depends on nothing.
package wtoq_pkg;

   localparam int NUM_SLOTS_DEF = 64;  // default slot count
   localparam int TIME_W        = 64;  // 48.16 wake time
   localparam int NOW_W         = 63;  // driver position
   localparam int SERIAL_W      = 32;
   localparam int SLOT_PORT_W   = 6;
   localparam int OPCODE_W      = 3;
   localparam int STATUS_W      = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD       = 3'd0,
      OP_SCHED_ABS = 3'd1,
      OP_SCHED_REL = 3'd2,
      OP_GET       = 3'd3,
      OP_REMOVE    = 3'd4,
      OP_ERASE     = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_NEG_TIME = 2'd1,
      STAT_NONE_DUE = 2'd2,
      STAT_IGNORED  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GET_HEAD,
      ST_UNQ,
      ST_INS_SETUP,
      ST_INS,
      ST_INS_FRONT
   } state_type;

endpackage

FILE: rtl/wake_time_ordered_task_queue_unit.sv
// Wake-time ordered task queue: sorted queue memory, slot flags and sequencer.
// Depends on wtoq_pkg for opcodes, status codes, state type and widths.
//
// One command is taken when req_start is high and busy is low; exactly one
// response beat follows on rsp_strobe, one cycle long, which the receiver must
// take as it comes. Commands that do not touch the queue (out-of-range slot,
// rejected schedule, ignored remove, get on an empty queue, unused opcodes)
// answer in the next cycle and the block is ready again at once. The queue is
// kept sorted in a memory of {slot, wake time} entries with one read and one
// write port, walked one entry per cycle: leaving the queue walks every entry,
// an insertion reads the tail and then walks back over each entry that wakes
// later (into an empty queue the new entry is written directly), and a get
// first reads the head. The response beat comes in the same cycle that busy
// falls. The worst case is a reschedule with a full queue. No clearing pass
// follows reset.
module wake_time_ordered_task_queue_unit #(
   parameter int NUM_SLOTS = wtoq_pkg::NUM_SLOTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_start,
   output logic                               busy,
   input  logic [wtoq_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [wtoq_pkg::SLOT_PORT_W-1:0]   req_task_slot,
   input  logic signed [wtoq_pkg::TIME_W-1:0] req_wake_time,
   input  logic [wtoq_pkg::NOW_W-1:0]         req_now,
   output logic                               rsp_strobe,
   output logic [wtoq_pkg::SLOT_PORT_W-1:0]   rsp_result_slot,
   output logic                               rsp_slot_valid,
   output logic [wtoq_pkg::SERIAL_W-1:0]      rsp_serial,
   output logic [wtoq_pkg::STATUS_W-1:0]      rsp_status,
   output logic                               rsp_stop,
   input  logic                               csr_wr_en,
   input  logic                               csr_wr_data
);

   localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
   localparam int TIME_W  = wtoq_pkg::TIME_W;
   localparam int ENTRY_W = SLOT_W + TIME_W;

   // queue memory: entry = {slot, wake time}
   logic [ENTRY_W-1:0]  queue_mem [NUM_SLOTS];
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic [SLOT_W-1:0]   rd_addr;
   logic                mem_we;
   logic [SLOT_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0]  mem_wdata;

   wtoq_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    qlen_ff, qlen_in;
   logic [CNT_W-1:0]    act_cnt_ff, act_cnt_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic                found_ff, found_in;
   logic                ins_ff, ins_in;
   logic [SLOT_W-1:0]   target_ff, target_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [NUM_SLOTS-1:0] queued_ff, queued_in;
   logic [NUM_SLOTS-1:0] erased_ff, erased_in;
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic [wtoq_pkg::SERIAL_W-1:0] serial_ff, serial_in;
   logic                keep_ff;

   logic                              strobe_ff, strobe_in;
   logic [wtoq_pkg::SLOT_PORT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [wtoq_pkg::SERIAL_W-1:0]     rsp_serial_ff, rsp_serial_in;
   wtoq_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic                              rsp_stop_ff, rsp_stop_in;

   // decoded command and datapath helpers
   logic                 accept;
   wtoq_pkg::opcode_type op;
   logic [SLOT_W-1:0]    slot_idx;
   logic                 slot_ok;
   logic [TIME_W-1:0]    wraw;
   logic [TIME_W-1:0]    now_ext;
   logic [TIME_W-1:0]    sched_time;
   logic                 below_now;
   logic [SLOT_W-1:0]    d_slot;
   logic [TIME_W-1:0]    d_wake;
   logic                 head_due;
   logic                 d_later;
   logic                 unq_last;
   logic                 no_active;
   logic [ENTRY_W-1:0]   new_entry;

   assign busy     = (state_ff != wtoq_pkg::ST_IDLE);
   assign accept   = req_start && !busy;
   assign op       = wtoq_pkg::opcode_type'(req_opcode);
   assign slot_idx = SLOT_W'(req_task_slot);
   assign slot_ok  = (32'(req_task_slot) < NUM_SLOTS);
   assign wraw     = req_wake_time;
   assign now_ext  = TIME_W'(req_now);
   assign sched_time = (op == wtoq_pkg::OP_SCHED_ABS) ? wraw : wraw + now_ext;
   assign below_now  = wraw[TIME_W-1] || ((op == wtoq_pkg::OP_SCHED_ABS) && (wraw < now_ext));

   assign d_slot    = rd_data_ff[ENTRY_W-1:TIME_W];
   assign d_wake    = rd_data_ff[TIME_W-1:0];
   assign head_due  = (d_wake <= time_ff);   // time_ff holds now + 1 on a get
   assign d_later   = (d_wake > time_ff);
   assign unq_last  = (CNT_W'(idx_ff) == qlen_ff - CNT_W'(1));
   assign no_active = !keep_ff && (act_cnt_ff == '0);
   assign new_entry = {target_ff, time_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wtoq_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (op)
                  wtoq_pkg::OP_GET: begin
                     if (qlen_ff != '0) state_in = wtoq_pkg::ST_GET_HEAD;
                  end
                  wtoq_pkg::OP_ADD: begin
                     if (slot_ok) begin
                        state_in = queued_ff[slot_idx] ? wtoq_pkg::ST_UNQ
                                                       : wtoq_pkg::ST_INS_SETUP;
                     end
                  end
                  wtoq_pkg::OP_SCHED_ABS, wtoq_pkg::OP_SCHED_REL: begin
                     if (slot_ok && !below_now && !erased_ff[slot_idx]) begin
                        state_in = queued_ff[slot_idx] ? wtoq_pkg::ST_UNQ
                                                       : wtoq_pkg::ST_INS_SETUP;
                     end
                  end
                  wtoq_pkg::OP_REMOVE, wtoq_pkg::OP_ERASE: begin
                     if (slot_ok && !erased_ff[slot_idx] && queued_ff[slot_idx]) begin
                        state_in = wtoq_pkg::ST_UNQ;
                     end
                  end
                  default: state_in = wtoq_pkg::ST_IDLE;
               endcase
            end
         end
         wtoq_pkg::ST_GET_HEAD: begin
            state_in = head_due ? wtoq_pkg::ST_UNQ : wtoq_pkg::ST_IDLE;
         end
         wtoq_pkg::ST_UNQ: begin
            if (unq_last) begin
               state_in = ins_ff ? wtoq_pkg::ST_INS_SETUP : wtoq_pkg::ST_IDLE;
            end
         end
         wtoq_pkg::ST_INS_SETUP: begin
            state_in = (qlen_ff == '0) ? wtoq_pkg::ST_IDLE : wtoq_pkg::ST_INS;
         end
         wtoq_pkg::ST_INS: begin
            if (!d_later) state_in = wtoq_pkg::ST_IDLE;
            else if (idx_ff == '0) state_in = wtoq_pkg::ST_INS_FRONT;
         end
         wtoq_pkg::ST_INS_FRONT: state_in = wtoq_pkg::ST_IDLE;
         default: state_in = wtoq_pkg::ST_IDLE;
      endcase
   end

   // datapath, flags, memory port and response
   always_comb begin
      qlen_in       = qlen_ff;
      act_cnt_in    = act_cnt_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      ins_in        = ins_ff;
      target_in     = target_ff;
      time_in       = time_ff;
      queued_in     = queued_ff;
      erased_in     = erased_ff;
      active_in     = active_ff;
      serial_in     = serial_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_serial_in = rsp_serial_ff;
      rsp_status_in = rsp_status_ff;
      rsp_stop_in   = rsp_stop_ff;
      rd_addr       = '0;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = new_entry;

      unique case (state_ff)
         wtoq_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_slot_in   = req_task_slot;
               rsp_valid_in  = 1'b0;
               rsp_serial_in = '0;
               rsp_status_in = wtoq_pkg::STAT_OK;
               rsp_stop_in   = 1'b0;
               target_in     = slot_idx;
               ins_in        = 1'b0;
               idx_in        = '0;
               found_in      = 1'b0;
               unique case (op)
                  wtoq_pkg::OP_GET: begin
                     time_in = now_ext + TIME_W'(1);
                     if (qlen_ff == '0) begin
                        rsp_status_in = wtoq_pkg::STAT_NONE_DUE;
                        rsp_stop_in   = no_active;
                     end
                  end
                  wtoq_pkg::OP_ADD: begin
                     if (slot_ok) begin
                        erased_in[slot_idx] = 1'b0;
                        queued_in[slot_idx] = 1'b1;
                        if (!active_ff[slot_idx]) begin
                           active_in[slot_idx] = 1'b1;
                           act_cnt_in          = act_cnt_ff + CNT_W'(1);
                        end
                        serial_in     = serial_ff + wtoq_pkg::SERIAL_W'(1);
                        rsp_serial_in = serial_ff + wtoq_pkg::SERIAL_W'(1);
                        time_in       = TIME_W'(1);
                        ins_in        = 1'b1;
                     end
                  end
                  wtoq_pkg::OP_SCHED_ABS, wtoq_pkg::OP_SCHED_REL: begin
                     if (slot_ok) begin
                        if (below_now) begin
                           rsp_status_in = wtoq_pkg::STAT_NEG_TIME;
                        end else if (erased_ff[slot_idx]) begin
                           rsp_status_in = wtoq_pkg::STAT_IGNORED;
                        end else begin
                           queued_in[slot_idx] = 1'b1;
                           time_in             = sched_time;
                           ins_in              = 1'b1;
                        end
                     end
                  end
                  wtoq_pkg::OP_REMOVE, wtoq_pkg::OP_ERASE: begin
                     if (slot_ok) begin
                        if (erased_ff[slot_idx]) begin
                           rsp_status_in = wtoq_pkg::STAT_IGNORED;
                        end else begin
                           queued_in[slot_idx] = 1'b0;
                           if (op == wtoq_pkg::OP_ERASE) begin
                              erased_in[slot_idx] = 1'b1;
                              active_in[slot_idx] = 1'b0;
                              if (active_ff[slot_idx]) act_cnt_in = act_cnt_ff - CNT_W'(1);
                           end
                        end
                     end
                  end
                  default: rsp_status_in = wtoq_pkg::STAT_OK;
               endcase
            end
         end
         wtoq_pkg::ST_GET_HEAD: begin
            // re-read entry 0 so the removal walk starts at the head
            if (head_due) begin
               rsp_slot_in       = wtoq_pkg::SLOT_PORT_W'(d_slot);
               rsp_valid_in      = 1'b1;
               queued_in[d_slot] = 1'b0;
               target_in         = d_slot;
            end else begin
               rsp_status_in = wtoq_pkg::STAT_NONE_DUE;
               rsp_stop_in   = no_active;
            end
         end
         wtoq_pkg::ST_UNQ: begin
            // close the gap: every entry after the target moves down one place
            rd_addr = idx_ff + SLOT_W'(1);
            if (found_ff) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff - SLOT_W'(1);
               mem_wdata = rd_data_ff;
            end
            if (d_slot == target_ff) found_in = 1'b1;
            if (unq_last) begin
               qlen_in  = qlen_ff - CNT_W'(1);
               found_in = 1'b0;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         wtoq_pkg::ST_INS_SETUP: begin
            rd_addr = SLOT_W'(qlen_ff - CNT_W'(1));
            idx_in  = SLOT_W'(qlen_ff - CNT_W'(1));
            if (qlen_ff == '0) begin
               mem_we    = 1'b1;
               mem_waddr = '0;
               qlen_in   = qlen_ff + CNT_W'(1);
            end
         end
         wtoq_pkg::ST_INS: begin
            // walk back from the tail; later wakers shift up one place
            rd_addr   = idx_ff - SLOT_W'(1);
            mem_we    = 1'b1;
            mem_waddr = idx_ff + SLOT_W'(1);
            if (d_later) begin
               mem_wdata = rd_data_ff;
               idx_in    = idx_ff - SLOT_W'(1);
            end else begin
               qlen_in = qlen_ff + CNT_W'(1);
            end
         end
         wtoq_pkg::ST_INS_FRONT: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            qlen_in   = qlen_ff + CNT_W'(1);
         end
         default: mem_we = 1'b0;
      endcase
   end

   // one response beat when a command completes
   assign strobe_in = (state_in == wtoq_pkg::ST_IDLE) && (accept || busy);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= wtoq_pkg::ST_IDLE;
         qlen_ff    <= '0;
         act_cnt_ff <= '0;
         idx_ff     <= '0;
         found_ff   <= 1'b0;
         ins_ff     <= 1'b0;
         queued_ff  <= '0;
         erased_ff  <= '0;
         active_ff  <= '0;
         serial_ff  <= '0;
         keep_ff    <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         qlen_ff    <= qlen_in;
         act_cnt_ff <= act_cnt_in;
         idx_ff     <= idx_in;
         found_ff   <= found_in;
         ins_ff     <= ins_in;
         queued_ff  <= queued_in;
         erased_ff  <= erased_in;
         active_ff  <= active_in;
         serial_ff  <= serial_in;
         strobe_ff  <= strobe_in;
         if (csr_wr_en) keep_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      target_ff     <= target_in;
      time_ff       <= time_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_valid_ff  <= rsp_valid_in;
      rsp_serial_ff <= rsp_serial_in;
      rsp_status_ff <= rsp_status_in;
      rsp_stop_ff   <= rsp_stop_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) queue_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= queue_mem[rd_addr];
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_result_slot = rsp_slot_ff;
   assign rsp_slot_valid  = rsp_valid_ff;
   assign rsp_serial      = rsp_serial_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_stop        = rsp_stop_ff;

endmodule

FILE: rtl/wtoq_checker.sv
// Port-level checker for the wake-time ordered task queue, bound to the top.
// Depends on wtoq_pkg for widths and status codes.
module wtoq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_start,
   input logic                               busy,
   input logic                               rsp_strobe,
   input logic                               rsp_slot_valid,
   input logic [wtoq_pkg::SERIAL_W-1:0]      rsp_serial,
   input logic [wtoq_pkg::STATUS_W-1:0]      rsp_status,
   input logic                               rsp_stop
);

   // an accepted command either keeps the block busy or answers next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      req_start && !busy |=> busy || rsp_strobe)
      else $error("accepted command neither busy nor answered");

   // a response beat only leaves on completion, never mid-walk
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response beat while busy");

   a_popped_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_slot_valid |->
         rsp_status == wtoq_pkg::STAT_OK && !rsp_stop && rsp_serial == '0)
      else $error("popped task with bad status, stop or serial");

   a_stop_none_due: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_stop |->
         rsp_status == wtoq_pkg::STAT_NONE_DUE && !rsp_slot_valid)
      else $error("stop without nothing-due status");

   a_serial_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_serial != '0 |-> rsp_status == wtoq_pkg::STAT_OK)
      else $error("serial on a failed command");

endmodule

bind wake_time_ordered_task_queue_unit wtoq_checker u_wtoq_checker (.*);
